// ===== rtl/core/ctpd_pkg.sv =====
// Shared types, constants and helpers for the cam tooth pattern decoder.
// Used by ctpd_mul, ctpd_div and cam_tooth_pattern_decoder; depends on nothing.
`default_nettype none

package ctpd_pkg;

    // default timer width in bits
    localparam int TIMER_WIDTH_DEF = 32;

    // datapath widths
    localparam int TIME_W     = 32;
    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 16;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int DIV_W      = 16;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STEPS  = PROD_W / DIV_BITS;
    localparam int ANGLE_W    = 16;
    localparam int CYL_W      = 4;
    localparam int STAGE_W    = 2;

    // saturated period value
    localparam logic [TIME_W-1:0] PERIOD_MAX = '1;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_RUNNING_THRESHOLD   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_RESOLUTION  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_RATIO          = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RATIO_RESOLUTION    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMER_COEFFICIENT   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_DESIRED_COEFFICIENT = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_CYLINDER_TABLE      = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_EVENTS_ENABLED      = 3'd7;

    // pattern stage codes
    localparam logic [STAGE_W-1:0] STAGE_NONE     = 2'd0;
    localparam logic [STAGE_W-1:0] STAGE_TWO_LEFT = 2'd1;
    localparam logic [STAGE_W-1:0] STAGE_ONE_LEFT = 2'd2;
    localparam logic [STAGE_W-1:0] STAGE_DETECTED = 2'd3;

    // cylinder table slots
    localparam logic [1:0] SLOT_SHORT_SHORT = 2'd0;
    localparam logic [1:0] SLOT_LONG_SHORT  = 2'd1;
    localparam logic [1:0] SLOT_LONG_LONG   = 2'd2;
    localparam logic [1:0] SLOT_SHORT_LONG  = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_SCALE,
        ST_DIV_LOAD,
        ST_DIVIDE,
        ST_RATIO,
        ST_LONG,
        ST_RESULT
    } state_t;

    // divider status towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // table slot from current and previous tooth type
    function automatic logic [1:0] cyl_slot(input logic cur_long, input logic prv_long);
        logic [1:0] slot;
        if (cur_long)
        begin
            slot = prv_long ? SLOT_LONG_LONG : SLOT_LONG_SHORT;
        end
        else
        begin
            slot = prv_long ? SLOT_SHORT_LONG : SLOT_SHORT_SHORT;
        end
        return slot;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ctpd_mul.sv =====
// Shared 32 x 16 unsigned multiplier with a registered product.
// Depends on ctpd_pkg for widths.
`default_nettype none

module ctpd_mul (
    input  wire logic                          clk,
    input  wire logic [ctpd_pkg::MUL_A_W-1:0]  a,
    input  wire logic [ctpd_pkg::MUL_B_W-1:0]  b,
    output logic      [ctpd_pkg::PROD_W-1:0]   prod
);

    logic [ctpd_pkg::PROD_W-1:0] prod_reg;

    // product is registered and lands in the cycle after the operands
    always_ff @(posedge clk)
    begin
        prod_reg <= ctpd_pkg::PROD_W'(a) * ctpd_pkg::PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ctpd_div.sv =====
// Restoring divider, 48-bit dividend by 16-bit divisor, two quotient bits per cycle.
// Depends on ctpd_pkg for widths and the status struct.
`default_nettype none

module ctpd_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [ctpd_pkg::PROD_W-1:0]   dividend,
    input  wire logic [ctpd_pkg::DIV_W-1:0]    divisor,
    output logic      [ctpd_pkg::PROD_W-1:0]   quotient,
    output ctpd_pkg::div_status_t              status
);

    localparam int CNT_W = $clog2(ctpd_pkg::DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ctpd_pkg::DIV_STEPS - 1);

    logic [ctpd_pkg::PROD_W-1:0] quot_reg;
    logic [ctpd_pkg::PROD_W-1:0] quot_next;
    logic [ctpd_pkg::DIV_W-1:0]  rem_reg;
    logic [ctpd_pkg::DIV_W-1:0]  rem_next;
    logic [ctpd_pkg::DIV_W-1:0]  dsr_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    // two shift-compare-subtract steps
    always_comb
    begin
        logic [ctpd_pkg::DIV_W:0]    tmp;
        logic [ctpd_pkg::DIV_W-1:0]  rem_v;
        logic [ctpd_pkg::PROD_W-1:0] q_v;
        rem_v = rem_reg;
        q_v   = quot_reg;
        for (int i = 0; i < ctpd_pkg::DIV_BITS; i++)
        begin
            tmp = {rem_v, q_v[ctpd_pkg::PROD_W-1]};
            q_v = {q_v[ctpd_pkg::PROD_W-2:0], 1'b0};
            if (tmp >= {1'b0, dsr_reg})
            begin
                tmp    = tmp - {1'b0, dsr_reg};
                q_v[0] = 1'b1;
            end
            rem_v = tmp[ctpd_pkg::DIV_W-1:0];
        end
        rem_next  = rem_v;
        quot_next = q_v;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dsr_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign quotient    = quot_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

    // done only follows a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    // a division started is busy next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not start");

    // busy and done never together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("divider busy and done at once");

endmodule

`default_nettype wire

// ===== rtl/core/cam_tooth_pattern_decoder.sv =====
// Cam tooth pattern decoder top level: sequencer, state, configuration and result register.
// Depends on ctpd_pkg, ctpd_mul and ctpd_div.
//
// One cam edge item is taken at a time and the input stalls until its result is in the
// output register. A rising edge or the very first falling edge goes through take and result.
// Every later falling edge goes through take, phase sum, scaling multiply, divider load,
// the divide step (24 steps of two quotient bits over the 48-bit product, then done), ratio,
// long tooth test and result. The one shared 32 x 16 multiplier forms the scaling product,
// then the running threshold product while the divider runs, then the two long tooth products.
// The result register lets a finished result wait while the next edge is taken; a result
// still held by the output stall keeps the next one in its result step.
// Configuration writes are always ready and must be made while no edge is in flight.
`default_nettype none

module cam_tooth_pattern_decoder #(
    parameter int TIMER_WIDTH = ctpd_pkg::TIMER_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ctpd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [ctpd_pkg::CFG_DATA_W-1:0]   cfg_data,
    // cam edge items
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [ctpd_pkg::TIME_W-1:0]       edge_time,
    input  wire logic                              pin_level,
    input  wire logic                              crank_synced,
    input  wire logic [ctpd_pkg::ANGLE_W-1:0]      crank_angle,
    // result items
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [ctpd_pkg::TIME_W-1:0]       tooth_period,
    output logic                                   tooth_long,
    output logic      [ctpd_pkg::STAGE_W-1:0]      pattern_stage,
    output logic      [ctpd_pkg::CYL_W-1:0]        cylinder,
    output logic                                   cylinder_valid,
    output logic                                   detect_event,
    output logic                                   run_event,
    output logic                                   position_available,
    output logic      [ctpd_pkg::ANGLE_W-1:0]      engine_angle,
    output logic                                   processed
);

    localparam logic [ctpd_pkg::TIME_W-1:0] TIME_MASK =
        ctpd_pkg::TIME_W'((33'd1 << TIMER_WIDTH) - 33'd1);

    // configuration registers
    logic [7:0]  run_thr_reg;
    logic [15:0] timeout_res_reg;
    logic [7:0]  long_ratio_reg;
    logic [7:0]  ratio_res_reg;
    logic [15:0] timer_coef_reg;
    logic [15:0] desired_coef_reg;
    logic [15:0] cyl_table_reg;
    logic        events_en_reg;

    // sequencer
    ctpd_pkg::state_t state_reg;
    ctpd_pkg::state_t state_next;

    // latched item
    logic [ctpd_pkg::TIME_W-1:0]  t_in_reg;
    logic                         level_in_reg;
    logic                         synced_in_reg;
    logic [ctpd_pkg::ANGLE_W-1:0] angle_in_reg;

    // decoder state
    logic [ctpd_pkg::TIME_W-1:0]  last_edge_time_reg, last_edge_time_next;
    logic [ctpd_pkg::TIME_W-1:0]  low_phase_reg, low_phase_next;
    logic                         first_period_reg, first_period_next;
    logic [ctpd_pkg::STAGE_W-1:0] stage_reg, stage_next;
    logic                         detected_reg, detected_next;
    logic                         running_reg, running_next;
    logic                         prev_long_reg, prev_long_next;
    logic [ctpd_pkg::TIME_W-1:0]  period_reg, period_next;
    logic [ctpd_pkg::CYL_W-1:0]   last_cylinder_reg, last_cylinder_next;
    logic [ctpd_pkg::ANGLE_W-1:0] angle_reg, angle_next;

    // work registers
    logic [ctpd_pkg::TIME_W-1:0]  sum_reg;
    logic [ctpd_pkg::TIME_W-1:0]  period_new_reg;
    logic                         run_ok_reg;
    logic [ctpd_pkg::PROD_W-1:0]  ratio_prod_reg;

    // result register
    logic                         out_valid_reg;
    logic [ctpd_pkg::TIME_W-1:0]  tooth_period_reg;
    logic                         tooth_long_reg, tooth_long_next;
    logic [ctpd_pkg::STAGE_W-1:0] pattern_stage_reg;
    logic [ctpd_pkg::CYL_W-1:0]   cylinder_reg;
    logic                         cylinder_valid_reg, cylinder_valid_next;
    logic                         detect_event_reg, detect_event_next;
    logic                         run_event_reg, run_event_next;
    logic                         position_reg, position_next;
    logic [ctpd_pkg::ANGLE_W-1:0] engine_angle_reg;
    logic                         processed_reg, processed_next;

    // shared units
    logic [ctpd_pkg::MUL_A_W-1:0] mul_a;
    logic [ctpd_pkg::MUL_B_W-1:0] mul_b;
    logic [ctpd_pkg::PROD_W-1:0]  prod;
    logic                         div_start;
    logic [ctpd_pkg::PROD_W-1:0]  quotient;
    ctpd_pkg::div_status_t        div_stat;

    logic                         in_accept;
    logic                         commit;
    logic [ctpd_pkg::TIME_W-1:0]  delta;
    logic [ctpd_pkg::TIME_W:0]    sum_full;

    ctpd_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    ctpd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod),
        .divisor  (desired_coef_reg),
        .quotient (quotient),
        .status   (div_stat)
    );

    // handshakes
    assign cfg_ready = 1'b1;
    assign in_accept = in_valid && !in_stall;
    assign commit    = (state_reg == ctpd_pkg::ST_RESULT) && (!out_valid_reg || !out_stall);

    // masked time since the last edge and full period with its carry bit, saturated in the sum step
    assign delta    = (t_in_reg - last_edge_time_reg) & TIME_MASK;
    assign sum_full = {1'b0, low_phase_reg} + {1'b0, delta};

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_thr_reg      <= 8'd10;
            timeout_res_reg  <= 16'd1000;
            long_ratio_reg   <= 8'd3;
            ratio_res_reg    <= 8'd2;
            timer_coef_reg   <= 16'd1;
            desired_coef_reg <= 16'd1;
            cyl_table_reg    <= 16'd0;
            events_en_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ctpd_pkg::CFG_RUNNING_THRESHOLD:   run_thr_reg      <= cfg_data[7:0];
                ctpd_pkg::CFG_TIMEOUT_RESOLUTION:  timeout_res_reg  <= cfg_data;
                ctpd_pkg::CFG_LONG_RATIO:          long_ratio_reg   <= cfg_data[7:0];
                ctpd_pkg::CFG_RATIO_RESOLUTION:    ratio_res_reg    <= cfg_data[7:0];
                ctpd_pkg::CFG_TIMER_COEFFICIENT:   timer_coef_reg   <= cfg_data;
                ctpd_pkg::CFG_DESIRED_COEFFICIENT: desired_coef_reg <= cfg_data;
                ctpd_pkg::CFG_CYLINDER_TABLE:      cyl_table_reg    <= cfg_data;
                ctpd_pkg::CFG_EVENTS_ENABLED:      events_en_reg    <= cfg_data[0];
                default:                           events_en_reg    <= events_en_reg;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ctpd_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (pin_level || first_period_reg) ? ctpd_pkg::ST_RESULT
                                                                 : ctpd_pkg::ST_SUM;
                end
            end
            ctpd_pkg::ST_SUM:      state_next = ctpd_pkg::ST_SCALE;
            ctpd_pkg::ST_SCALE:    state_next = ctpd_pkg::ST_DIV_LOAD;
            ctpd_pkg::ST_DIV_LOAD: state_next = ctpd_pkg::ST_DIVIDE;
            ctpd_pkg::ST_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    state_next = ctpd_pkg::ST_RATIO;
                end
            end
            ctpd_pkg::ST_RATIO:    state_next = ctpd_pkg::ST_LONG;
            ctpd_pkg::ST_LONG:     state_next = ctpd_pkg::ST_RESULT;
            ctpd_pkg::ST_RESULT:
            begin
                if (commit)
                begin
                    state_next = ctpd_pkg::ST_IDLE;
                end
            end
            default:               state_next = ctpd_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: input stall, divider start and multiplier operands
    always_comb
    begin
        in_stall  = (state_reg != ctpd_pkg::ST_IDLE);
        div_start = (state_reg == ctpd_pkg::ST_DIV_LOAD);
        case (state_reg)
            ctpd_pkg::ST_SCALE:
            begin
                mul_a = sum_reg;
                mul_b = timer_coef_reg;
            end
            ctpd_pkg::ST_DIV_LOAD, ctpd_pkg::ST_DIVIDE:
            begin
                mul_a = ctpd_pkg::MUL_A_W'(run_thr_reg);
                mul_b = timeout_res_reg;
            end
            ctpd_pkg::ST_RATIO:
            begin
                mul_a = period_new_reg;
                mul_b = ctpd_pkg::MUL_B_W'(ratio_res_reg);
            end
            default:
            begin
                mul_a = low_phase_reg;
                mul_b = ctpd_pkg::MUL_B_W'(long_ratio_reg);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ctpd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // item latch and intermediate results
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            t_in_reg      <= edge_time;
            level_in_reg  <= pin_level;
            synced_in_reg <= crank_synced;
            angle_in_reg  <= crank_angle;
        end
        if (state_reg == ctpd_pkg::ST_SUM)
        begin
            sum_reg <= sum_full[ctpd_pkg::TIME_W] ? ctpd_pkg::PERIOD_MAX
                                                  : sum_full[ctpd_pkg::TIME_W-1:0];
        end
        if ((state_reg == ctpd_pkg::ST_DIVIDE) && div_stat.done)
        begin
            if ((desired_coef_reg == '0) || (|quotient[ctpd_pkg::PROD_W-1:ctpd_pkg::TIME_W]))
            begin
                period_new_reg <= ctpd_pkg::PERIOD_MAX;
            end
            else
            begin
                period_new_reg <= quotient[ctpd_pkg::TIME_W-1:0];
            end
        end
        // threshold product is in the multiplier register here
        if (state_reg == ctpd_pkg::ST_RATIO)
        begin
            run_ok_reg <= (ctpd_pkg::PROD_W'(period_new_reg) <= prod);
        end
        if (state_reg == ctpd_pkg::ST_LONG)
        begin
            ratio_prod_reg <= prod;
        end
    end

    // state update and result fields at commit
    always_comb
    begin
        logic is_long;
        is_long             = ratio_prod_reg < prod;
        last_edge_time_next = t_in_reg;
        low_phase_next      = low_phase_reg;
        first_period_next   = first_period_reg;
        stage_next          = stage_reg;
        detected_next       = detected_reg;
        running_next        = running_reg;
        prev_long_next      = prev_long_reg;
        period_next         = period_reg;
        last_cylinder_next  = last_cylinder_reg;
        angle_next          = angle_reg;
        tooth_long_next     = 1'b0;
        cylinder_valid_next = 1'b0;
        detect_event_next   = 1'b0;
        run_event_next      = 1'b0;
        position_next       = 1'b0;
        processed_next      = 1'b0;
        if (level_in_reg)
        begin
            low_phase_next = delta;
        end
        else if (first_period_reg)
        begin
            first_period_next = 1'b0;
            stage_next        = ctpd_pkg::STAGE_TWO_LEFT;
        end
        else
        begin
            period_next = period_new_reg;
            if (!detected_reg)
            begin
                detected_next     = 1'b1;
                detect_event_next = events_en_reg;
            end
            if (run_ok_reg && !running_reg)
            begin
                running_next   = 1'b1;
                run_event_next = events_en_reg;
            end
            tooth_long_next = is_long;
            if (stage_reg != ctpd_pkg::STAGE_DETECTED)
            begin
                stage_next = stage_reg + 1'b1;
            end
            // cylinder lookup from the last two tooth types
            if ((stage_reg == ctpd_pkg::STAGE_ONE_LEFT) || (stage_reg == ctpd_pkg::STAGE_DETECTED))
            begin
                last_cylinder_next  = cyl_table_reg[ctpd_pkg::cyl_slot(is_long, prev_long_reg)
                                                    * ctpd_pkg::CYL_W +: ctpd_pkg::CYL_W];
                cylinder_valid_next = 1'b1;
            end
            prev_long_next = is_long;
            position_next  = synced_in_reg;
            angle_next     = angle_in_reg;
            processed_next = 1'b1;
        end
    end

    // decoder state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_edge_time_reg <= '0;
            low_phase_reg      <= '0;
            first_period_reg   <= 1'b1;
            stage_reg          <= ctpd_pkg::STAGE_NONE;
            detected_reg       <= 1'b0;
            running_reg        <= 1'b0;
            prev_long_reg      <= 1'b0;
            period_reg         <= '0;
            last_cylinder_reg  <= '0;
            angle_reg          <= '0;
        end
        else if (commit)
        begin
            last_edge_time_reg <= last_edge_time_next;
            low_phase_reg      <= low_phase_next;
            first_period_reg   <= first_period_next;
            stage_reg          <= stage_next;
            detected_reg       <= detected_next;
            running_reg        <= running_next;
            prev_long_reg      <= prev_long_next;
            period_reg         <= period_next;
            last_cylinder_reg  <= last_cylinder_next;
            angle_reg          <= angle_next;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            tooth_period_reg   <= period_next;
            tooth_long_reg     <= tooth_long_next;
            pattern_stage_reg  <= stage_next;
            cylinder_reg       <= last_cylinder_next;
            cylinder_valid_reg <= cylinder_valid_next;
            detect_event_reg   <= detect_event_next;
            run_event_reg      <= run_event_next;
            position_reg       <= position_next;
            engine_angle_reg   <= angle_next;
            processed_reg      <= processed_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign tooth_period       = tooth_period_reg;
    assign tooth_long         = tooth_long_reg;
    assign pattern_stage      = pattern_stage_reg;
    assign cylinder           = cylinder_reg;
    assign cylinder_valid     = cylinder_valid_reg;
    assign detect_event       = detect_event_reg;
    assign run_event          = run_event_reg;
    assign position_available = position_reg;
    assign engine_angle       = engine_angle_reg;
    assign processed          = processed_reg;

    // an accepted item always leaves idle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg != ctpd_pkg::ST_IDLE))
        else $error("item accepted but sequencer stayed idle");

    // detected pattern never falls back
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_reg == ctpd_pkg::STAGE_DETECTED) |=> (stage_reg == ctpd_pkg::STAGE_DETECTED))
        else $error("pattern stage left detected");

    // divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ctpd_pkg::ST_DIVIDE))
        else $error("divider done outside the divide step");

    // a processed edge always has an armed stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && processed_reg) |-> (pattern_stage_reg != ctpd_pkg::STAGE_NONE))
        else $error("processed edge with stage not armed");

    // a cylinder update belongs to a processed edge
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && cylinder_valid_reg) |-> processed_reg)
        else $error("cylinder update on an unprocessed edge");

endmodule

`default_nettype wire
